FILE: rtl/core/piq_pkg.sv
`timescale 1ns / 1ps

package piq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int POS_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRI_W       = 8;
    localparam int SEQ_W       = 32;
    localparam int HND_W       = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_ENQ  = 1'b0,
        FUNC_TAKE = 1'b1
    } t_func;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [SEQ_W-1:0] seq;
        logic [HND_W-1:0] hnd;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic take;
    } t_cell_ctl;

endpackage

FILE: rtl/core/priority_insertion_queue.sv
`timescale 1ns / 1ps
// channel   | signals                                                 | handshake
// ----------+---------------------------------------------------------+----------------------
// command   | i_func i_priority_req i_seq_num i_msg_handle            | start, busy
// result    | o_status o_position o_out_handle o_occupancy            | o_strobe, one cycle
//
// one transaction per cycle: every slot compares and shifts in the same cycle
// the result appears with o_strobe in the cycle after the transaction is taken
// synchronous reset empties the queue; busy is high during it and in the cycle after it
// results cannot be stalled; the receiver takes each one in its strobe cycle

module priority_insertion_queue import piq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_func,
    input  logic [PRI_W-1:0] i_priority_req,
    input  logic [SEQ_W-1:0] i_seq_num,
    input  logic [HND_W-1:0] i_msg_handle,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [POS_W-1:0] o_position,
    output logic [HND_W-1:0] o_out_handle,
    output logic [OCC_W-1:0] o_occupancy
);

    t_entry              c_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] c_valid;
    logic [QUEUE_DEPTH-1:0] c_beat;
    t_entry              new_entry;
    t_cell_ctl           ctl;

    logic                r_rdy;
    logic [OCC_W-1:0]    r_count;
    logic [OCC_W-1:0]    n_count;
    logic                r_strobe;
    t_status             r_status;
    t_status             n_status;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [HND_W-1:0]    r_hnd;
    logic [HND_W-1:0]    n_hnd;
    logic [POS_W-1:0]    ins_pos;

    logic accept;
    logic full;
    logic empty;

    assign busy      = !r_rdy;
    assign accept    = start && r_rdy;
    assign full      = (r_count == OCC_W'(QUEUE_DEPTH));
    assign empty     = (r_count == '0);
    assign new_entry = '{pri: i_priority_req, seq: i_seq_num, hnd: i_msg_handle};

    assign ctl.enq  = accept && (i_func == FUNC_ENQ) && !full;
    assign ctl.take = accept && (i_func == FUNC_TAKE) && !empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            piq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_new        (new_entry),
                .i_prev_entry (new_entry),
                .i_prev_valid (1'b0),
                .i_prev_beat  (1'b0),
                .i_next_entry (c_entry[g+1]),
                .i_next_valid (c_valid[g+1]),
                .o_entry      (c_entry[g]),
                .o_valid      (c_valid[g]),
                .o_beat       (c_beat[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_tail
            piq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_new        (new_entry),
                .i_prev_entry (c_entry[g-1]),
                .i_prev_valid (c_valid[g-1]),
                .i_prev_beat  (c_beat[g-1]),
                .i_next_entry (new_entry),
                .i_next_valid (1'b0),
                .o_entry      (c_entry[g]),
                .o_valid      (c_valid[g]),
                .o_beat       (c_beat[g])
            );
        end else begin : g_mid
            piq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_new        (new_entry),
                .i_prev_entry (c_entry[g-1]),
                .i_prev_valid (c_valid[g-1]),
                .i_prev_beat  (c_beat[g-1]),
                .i_next_entry (c_entry[g+1]),
                .i_next_valid (c_valid[g+1]),
                .o_entry      (c_entry[g]),
                .o_valid      (c_valid[g]),
                .o_beat       (c_beat[g])
            );
        end
    end

    // the insertion slot is the only beaten slot whose left neighbor was not beaten
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (c_beat[i] && ((i == 0) || !c_beat[(i == 0) ? 0 : i - 1])) begin
                ins_pos = ins_pos | POS_W'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pos    = '0;
        n_hnd    = '0;
        if (i_func == FUNC_ENQ) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_pos   = ins_pos;
                n_count = r_count + OCC_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_hnd   = c_entry[0].hnd;
                n_count = r_count - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy    <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_rdy    <= 1'b1;
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_hnd    <= n_hnd;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_position   = r_pos;
    assign o_out_handle = r_hnd;
    assign o_occupancy  = r_count;

endmodule

FILE: rtl/core/piq_cell.sv
`timescale 1ns / 1ps

module piq_cell import piq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev_entry,
    input  logic      i_prev_valid,
    input  logic      i_prev_beat,
    input  t_entry    i_next_entry,
    input  logic      i_next_valid,
    output t_entry    o_entry,
    output logic      o_valid,
    output logic      o_beat
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    // new entry wins over this slot, or this slot is free
    assign o_beat = !r_valid || (i_new.pri > r_entry.pri) ||
                    ((i_new.pri == r_entry.pri) && (i_new.seq < r_entry.seq));

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.enq) begin
            if (o_beat && !i_prev_beat) begin
                n_entry = i_new;
                n_valid = 1'b1;
            end else if (o_beat) begin
                n_entry = i_prev_entry;
                n_valid = i_prev_valid;
            end
        end else if (i_ctl.take) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

FILE: rtl/core/piq_checker.sv
`timescale 1ns / 1ps

module piq_checker import piq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input logic [1:0]       o_status,
    input logic [HND_W-1:0] o_out_handle,
    input logic [OCC_W-1:0] o_occupancy
);

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("missing result after transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without transaction");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("full reported below depth");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |-> (o_occupancy == '0 && o_out_handle == '0))
        else $error("empty result inconsistent");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && o_status == ST_OK) |->
            (o_occupancy == $past(o_occupancy) + OCC_W'(1) ||
             o_occupancy == $past(o_occupancy) - OCC_W'(1)))
        else $error("occupancy jumped");

endmodule

bind priority_insertion_queue piq_checker u_piq_checker (.*);
